@@ sv/plcm_pkg.sv @@
// ----------------------------------------------------------------------------
// plcm_pkg
// Shared types and constants for the piecewise-linear colour map.
// ----------------------------------------------------------------------------
package plcm_pkg;

  localparam int POS_W   = 16;
  localparam int COL_W   = 24;
  localparam int ENTRY_W = POS_W + COL_W;
  localparam int PROD_W  = 24;
  localparam int DIV_CNT_W = $clog2(PROD_W + 1);

  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_ADD_DECIDE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_INSERT,
    S_LK_DECIDE,
    S_RD_A,
    S_RD_B,
    S_LD_B,
    S_MUL,
    S_DIV_START,
    S_DIV_WAIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                start;
    logic [PROD_W-1:0]   dividend;
    logic [POS_W-1:0]    divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [PROD_W-1:0]   quotient;
    logic [POS_W-1:0]    remainder;
  } div_rsp_t;

  function automatic logic [7:0] chan_of(input logic [COL_W-1:0] col, input logic [1:0] ch);
    logic [7:0] r;
    begin
      case (ch)
        CH_RED:   r = col[23:16];
        CH_GREEN: r = col[15:8];
        CH_BLUE:  r = col[7:0];
        default:  r = 8'd0;
      endcase
      return r;
    end
  endfunction

endpackage

@@ sv/plcm_ram.sv @@
// ----------------------------------------------------------------------------
// plcm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module plcm_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/plcm_div.sv @@
// ----------------------------------------------------------------------------
// plcm_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module plcm_div (
  input  logic               clk,
  input  logic               rst,
  input  plcm_pkg::div_req_t req,
  output plcm_pkg::div_rsp_t rsp
);

  logic                               busy;
  logic                               done;
  logic [plcm_pkg::DIV_CNT_W-1:0]     cnt;
  logic [plcm_pkg::PROD_W-1:0]        quo;
  logic [plcm_pkg::POS_W-1:0]         rem;
  logic [plcm_pkg::POS_W-1:0]         dsr;
  logic [plcm_pkg::POS_W:0]           shifted;
  logic [plcm_pkg::POS_W:0]           trial;
  logic                               fits;

  assign shifted = {rem, quo[plcm_pkg::PROD_W-1]};
  assign trial   = shifted - {1'b0, dsr};
  assign fits    = (shifted >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= plcm_pkg::DIV_CNT_W'(plcm_pkg::PROD_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == plcm_pkg::DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dsr <= req.divisor;
    end else if (busy) begin
      quo <= {quo[plcm_pkg::PROD_W-2:0], fits};
      rem <= fits ? trial[plcm_pkg::POS_W-1:0] : shifted[plcm_pkg::POS_W-1:0];
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

@@ sv/piecewise_linear_color_map.sv @@
// ----------------------------------------------------------------------------
// piecewise_linear_color_map
// Sorted colour-stop table with linear interpolation of lookups.
// ----------------------------------------------------------------------------
// Holds up to MAX_STOPS colour stops in one RAM, sorted by position. Every
// transaction gives exactly one result and the input is stalled until the
// work for it is done. An add scans the RAM with one read plus one compare
// per stored stop, then moves each stop above the new position up by one
// place to open a gap and writes the new stop into it. A lookup scans and
// fetches two neighbouring stops, then the one bit-serial divider
// (24 quotient bits) is shared in turn by red, green and blue, and the
// result is handed to the output register. Lookups that need no
// interpolation (empty table, single stop, below the first stop) finish after
// the scan.
// ----------------------------------------------------------------------------
module piecewise_linear_color_map #(
  parameter int MAX_STOPS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              op,
  input  logic signed [15:0] position,
  input  logic [7:0]        red_in,
  input  logic [7:0]        green_in,
  input  logic [7:0]        blue_in,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        red_out,
  output logic [7:0]        green_out,
  output logic [7:0]        blue_out,
  output logic              in_range,
  output logic [1:0]        status
);

  localparam int IW = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
  localparam int CW = $clog2(MAX_STOPS + 1);

  plcm_pkg::state_t state, state_next;

  // transaction registers
  logic                               op_r;
  logic signed [plcm_pkg::POS_W-1:0]  v_r;
  logic [plcm_pkg::COL_W-1:0]         col_r;
  logic [CW-1:0]                      idx;
  logic [CW-1:0]                      cnt;
  logic [CW-1:0]                      kcnt;
  logic signed [plcm_pkg::POS_W-1:0]  pos0;
  logic [plcm_pkg::COL_W-1:0]         col0;
  logic signed [plcm_pkg::POS_W-1:0]  plast;
  logic signed [plcm_pkg::POS_W-1:0]  pa;
  logic [plcm_pkg::COL_W-1:0]         ca;
  logic [plcm_pkg::COL_W-1:0]         cb;
  logic [plcm_pkg::POS_W-1:0]         dv;
  logic [plcm_pkg::POS_W-1:0]         dp;
  logic [1:0]                         ch;
  logic                               neg;
  logic [7:0]                         a_ch;
  logic [plcm_pkg::PROD_W-1:0]        prod;
  logic [plcm_pkg::COL_W-1:0]         rgb_acc;
  logic                               range_r;
  logic [1:0]                         status_r;

  // ram
  logic                               we;
  logic [IW-1:0]                      waddr;
  logic [plcm_pkg::ENTRY_W-1:0]       wdata;
  logic [IW-1:0]                      raddr;
  logic [plcm_pkg::ENTRY_W-1:0]       rd_data;
  logic signed [plcm_pkg::POS_W-1:0]  rd_pos;
  logic [plcm_pkg::COL_W-1:0]         rd_col;

  plcm_pkg::div_req_t                 div_req;
  plcm_pkg::div_rsp_t                 div_rsp;

  logic [CW-1:0]                      idx_m1;
  logic [CW-1:0]                      idx_p1;
  logic [CW-1:0]                      km1;
  logic [CW-1:0]                      nm2;
  logic [CW-1:0]                      sel;
  logic                               full;
  logic                               take_out;
  logic                               below;
  logic signed [8:0]                  diff;
  logic [7:0]                         mag;
  logic [plcm_pkg::PROD_W:0]          qq;
  logic signed [plcm_pkg::PROD_W+1:0] sres;
  logic [7:0]                         sat;

  assign rd_pos   = rd_data[plcm_pkg::ENTRY_W-1:plcm_pkg::COL_W];
  assign rd_col   = rd_data[plcm_pkg::COL_W-1:0];
  assign idx_m1   = idx - CW'(1);
  assign idx_p1   = idx + CW'(1);
  assign km1      = kcnt - CW'(1);
  assign nm2      = cnt - CW'(2);
  assign sel      = (km1 > nm2) ? nm2 : km1;
  assign full     = (cnt == CW'(MAX_STOPS));
  assign take_out = !out_valid || !out_stall;
  assign below    = (v_r < pos0);
  assign in_stall = (state != plcm_pkg::S_IDLE);

  // channel difference and floor correction
  assign diff = $signed({1'b0, plcm_pkg::chan_of(cb, ch)})
              - $signed({1'b0, plcm_pkg::chan_of(ca, ch)});
  assign mag  = diff[8] ? 8'(-diff) : diff[7:0];
  assign qq   = {1'b0, div_rsp.quotient}
              + (plcm_pkg::PROD_W + 1)'(neg && (div_rsp.remainder != '0));
  assign sres = neg ? $signed({{(plcm_pkg::PROD_W - 6){1'b0}}, a_ch}) - $signed({1'b0, qq})
                    : $signed({{(plcm_pkg::PROD_W - 6){1'b0}}, a_ch}) + $signed({1'b0, qq});
  always_comb begin
    if (sres < 0) begin
      sat = 8'd0;
    end else if (sres > 255) begin
      sat = 8'd255;
    end else begin
      sat = sres[7:0];
    end
  end

  plcm_ram #(
    .WIDTH(plcm_pkg::ENTRY_W),
    .DEPTH(MAX_STOPS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd_data)
  );

  plcm_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= plcm_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next       = state;
    we               = 1'b0;
    waddr            = idx[IW-1:0];
    wdata            = {v_r, col_r};
    raddr            = idx[IW-1:0];
    div_req.start    = 1'b0;
    div_req.dividend = prod;
    div_req.divisor  = dp;
    case (state)
      plcm_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = plcm_pkg::S_SCAN_RD;
        end
      end
      plcm_pkg::S_SCAN_RD: begin
        if (idx == cnt) begin
          state_next = (op_r == plcm_pkg::OP_LOOKUP) ? plcm_pkg::S_LK_DECIDE
                                                     : plcm_pkg::S_ADD_DECIDE;
        end else begin
          state_next = plcm_pkg::S_SCAN_CHK;
        end
      end
      plcm_pkg::S_SCAN_CHK: begin
        if (op_r == plcm_pkg::OP_ADD && rd_pos == v_r) begin
          // same position: only the colour changes
          we         = 1'b1;
          state_next = plcm_pkg::S_DONE;
        end else begin
          state_next = plcm_pkg::S_SCAN_RD;
        end
      end
      plcm_pkg::S_ADD_DECIDE: begin
        state_next = full ? plcm_pkg::S_DONE : plcm_pkg::S_SHIFT_RD;
      end
      plcm_pkg::S_SHIFT_RD: begin
        raddr = idx_m1[IW-1:0];
        state_next = (idx == kcnt) ? plcm_pkg::S_INSERT : plcm_pkg::S_SHIFT_WR;
      end
      plcm_pkg::S_SHIFT_WR: begin
        we         = 1'b1;
        wdata      = rd_data;
        state_next = plcm_pkg::S_SHIFT_RD;
      end
      plcm_pkg::S_INSERT: begin
        we         = 1'b1;
        waddr      = kcnt[IW-1:0];
        state_next = plcm_pkg::S_DONE;
      end
      plcm_pkg::S_LK_DECIDE: begin
        if (cnt == '0 || cnt == CW'(1) || below) begin
          state_next = plcm_pkg::S_DONE;
        end else begin
          state_next = plcm_pkg::S_RD_A;
        end
      end
      plcm_pkg::S_RD_A: begin
        state_next = plcm_pkg::S_RD_B;
      end
      plcm_pkg::S_RD_B: begin
        raddr      = idx_p1[IW-1:0];
        state_next = plcm_pkg::S_LD_B;
      end
      plcm_pkg::S_LD_B: begin
        state_next = plcm_pkg::S_MUL;
      end
      plcm_pkg::S_MUL: begin
        state_next = plcm_pkg::S_DIV_START;
      end
      plcm_pkg::S_DIV_START: begin
        div_req.start = 1'b1;
        state_next    = plcm_pkg::S_DIV_WAIT;
      end
      plcm_pkg::S_DIV_WAIT: begin
        if (div_rsp.done) begin
          state_next = (ch == plcm_pkg::CH_BLUE) ? plcm_pkg::S_DONE : plcm_pkg::S_MUL;
        end
      end
      plcm_pkg::S_DONE: begin
        if (take_out) begin
          state_next = plcm_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = plcm_pkg::S_IDLE;
      end
    endcase
  end

  // stop count
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (state == plcm_pkg::S_INSERT) begin
      cnt <= cnt + CW'(1);
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      plcm_pkg::S_IDLE: begin
        if (in_valid) begin
          op_r     <= op;
          v_r      <= position;
          col_r    <= {red_in, green_in, blue_in};
          idx      <= '0;
          kcnt     <= '0;
          ch       <= plcm_pkg::CH_RED;
          rgb_acc  <= '0;
          range_r  <= 1'b0;
          status_r <= plcm_pkg::ST_OK;
        end
      end
      plcm_pkg::S_SCAN_CHK: begin
        if (idx == '0) begin
          pos0 <= rd_pos;
          col0 <= rd_col;
        end
        if (idx == cnt - CW'(1)) begin
          plast <= rd_pos;
        end
        // add counts stops below v, lookup counts stops at or below v
        if ((op_r == plcm_pkg::OP_LOOKUP) ? (rd_pos <= v_r) : (rd_pos < v_r)) begin
          kcnt <= kcnt + CW'(1);
        end
        idx <= idx_p1;
      end
      plcm_pkg::S_ADD_DECIDE: begin
        if (full) begin
          status_r <= plcm_pkg::ST_FULL;
        end
        idx <= cnt;
      end
      plcm_pkg::S_SHIFT_WR: begin
        idx <= idx_m1;
      end
      plcm_pkg::S_LK_DECIDE: begin
        if (cnt == '0) begin
          status_r <= plcm_pkg::ST_EMPTY;
        end else begin
          range_r <= !below && (v_r <= plast);
          if (cnt == CW'(1) || below) begin
            rgb_acc <= col0;
          end
        end
        idx <= sel;
      end
      plcm_pkg::S_RD_B: begin
        pa <= rd_pos;
        ca <= rd_col;
      end
      plcm_pkg::S_LD_B: begin
        cb <= rd_col;
        dv <= plcm_pkg::POS_W'(v_r - pa);
        dp <= plcm_pkg::POS_W'(rd_pos - pa);
      end
      plcm_pkg::S_MUL: begin
        a_ch <= plcm_pkg::chan_of(ca, ch);
        neg  <= diff[8];
        prod <= plcm_pkg::PROD_W'(dv) * plcm_pkg::PROD_W'(mag);
      end
      plcm_pkg::S_DIV_WAIT: begin
        if (div_rsp.done) begin
          case (ch)
            plcm_pkg::CH_RED:   rgb_acc[23:16] <= sat;
            plcm_pkg::CH_GREEN: rgb_acc[15:8]  <= sat;
            default:            rgb_acc[7:0]   <= sat;
          endcase
          ch <= ch + 2'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == plcm_pkg::S_DONE && take_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == plcm_pkg::S_DONE && take_out) begin
      red_out   <= rgb_acc[23:16];
      green_out <= rgb_acc[15:8];
      blue_out  <= rgb_acc[7:0];
      in_range  <= range_r;
      status    <= status_r;
    end
  end

endmodule

@@ sv/plcm_checker.sv @@
// ----------------------------------------------------------------------------
// plcm_checker
// Port-level checks for the piecewise-linear colour map.
// ----------------------------------------------------------------------------
module plcm_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              op,
  input logic signed [15:0] position,
  input logic [7:0]        red_in,
  input logic [7:0]        green_in,
  input logic [7:0]        blue_in,
  input logic              out_valid,
  input logic              out_stall,
  input logic [7:0]        red_out,
  input logic [7:0]        green_out,
  input logic [7:0]        blue_out,
  input logic              in_range,
  input logic [1:0]        status
);

  // a transaction keeps the input busy on the next cycle
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after a transaction");

  // a result only appears after the block has been busy
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without preceding work");

  // results flagged empty or full carry no colour and are not in range
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != plcm_pkg::ST_OK) |->
      (red_out == 8'd0 && green_out == 8'd0 && blue_out == 8'd0 && !in_range))
    else $error("flagged result carries colour");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == plcm_pkg::ST_OK || status == plcm_pkg::ST_EMPTY ||
                   status == plcm_pkg::ST_FULL))
    else $error("undefined status code");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(status) && $stable(red_out)))
    else $error("stalled result dropped or changed");

endmodule

bind piecewise_linear_color_map plcm_checker u_plcm_checker (.*);
